@@ src/nrp_pkg.sv @@
// ----------------------------------------------------------------------------
// nrp_pkg: shared types and constants of the RMC sentence parser
// Character codes, status codes, field positions and the result record.
// ----------------------------------------------------------------------------
package nrp_pkg;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  // Status codes
  localparam logic [2:0] ST_GP_OTHER   = 3'd0;
  localparam logic [2:0] ST_RMC_OK     = 3'd1;
  localparam logic [2:0] ST_RMC_SHORT  = 3'd2;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd3;
  localparam logic [2:0] ST_ABORT      = 3'd4;

  // Field numbers (after empty-field skipping)
  localparam logic [3:0] TOK_ID      = 4'd0;
  localparam logic [3:0] TOK_LAT     = 4'd3;
  localparam logic [3:0] TOK_LAT_HEM = 4'd4;
  localparam logic [3:0] TOK_LON     = 4'd5;
  localparam logic [3:0] TOK_LON_HEM = 4'd6;
  localparam logic [3:0] TOK_SPEED   = 4'd7;
  localparam logic [3:0] TOK_MAX     = 4'd15;

  localparam logic [1:0] PREFIX_LEN  = 2'd3;
  localparam logic [2:0] ID_LEN      = 3'd6;
  localparam logic [2:0] ID_MISMATCH = 3'd7;

  localparam logic [33:0] DIGIT_MAX  = 34'd999999999;
  localparam logic [3:0]  FRAC_MAX   = 4'd9;

  typedef struct packed {
    logic [2:0]  status;
    logic        truncated;
    logic [6:0]  length;
    logic [29:0] lat_digits;
    logic [3:0]  lat_frac_count;
    logic [7:0]  lat_hemisphere;
    logic [29:0] lon_digits;
    logic [3:0]  lon_frac_count;
    logic [7:0]  lon_hemisphere;
    logic [29:0] speed_digits;
    logic [3:0]  speed_frac_count;
    logic        number_overflow;
  } result_t;

  // Expected character of "$GP" at a position
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_DOLLAR;
      2'd1:    c = CH_G;
      2'd2:    c = CH_P;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Expected character of "$GPRMC" at a position
  function automatic logic [7:0] id_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_P;
      3'd3:    c = CH_R;
      3'd4:    c = CH_M;
      3'd5:    c = CH_C;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ src/nrp_ifs.sv @@
// ----------------------------------------------------------------------------
// nrp channel interfaces
// Valid/ready channels for received characters and for parse results.
// ----------------------------------------------------------------------------
interface nrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrp_result_if;
  logic             valid;
  logic             ready;
  nrp_pkg::result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

@@ src/nmea_rmc_sentence_parser_top.sv @@
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_top: NMEA 0183 RMC sentence parser
// Splits a character stream into sentences and extracts RMC position/speed.
// ----------------------------------------------------------------------------
// Usage:
//   serial : one received character per transfer (rx_byte).
//   report : one result per finished sentence. A sentence finishes on CR or
//            LF, on a character arriving once MAX_LEN characters are kept,
//            or on a second '$' (aborted). A CR/LF outside any sentence
//            reports bad prefix with length 0. Other characters give no
//            result.
//   One character is taken every cycle; the parse state advances in the
//   cycle of the transfer. A result appears on report the cycle after the
//   ending character's transfer and sits in a single output
//   register. While that register is full and report.ready is low, serial
//   stalls; when report.ready is high the next character is taken in the
//   same cycle the result leaves, so a stream runs at 1 character/cycle.
//   The decimal fields use one multiply-by-ten accumulate shared by the
//   latitude, longitude and speed fields (only one is open at a time).
//   Reset (synchronous rst) clears the parse state and empties the output.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_top #(
  parameter int MAX_LEN = 80
) (
  input  logic                clk,
  input  logic                rst,
  nrp_byte_if.sink            serial,
  nrp_result_if.source        report
);
  import nrp_pkg::*;

  localparam logic [6:0] LIMIT = 7'(MAX_LEN);

  // Parse state
  logic [6:0]  stored_count,   stored_count_next;
  logic [1:0]  prefix_match,   prefix_match_next;
  logic [2:0]  id_match_pos,   id_match_pos_next;
  logic        id_is_rmc,      id_is_rmc_next;
  logic [3:0]  token_number,   token_number_next;
  logic        token_nonempty, token_nonempty_next;
  logic        after_point,    after_point_next;
  logic        digit_stop,     digit_stop_next;
  logic [29:0] acc      [3];
  logic [29:0] acc_next [3];
  logic [3:0]  frac      [3];
  logic [3:0]  frac_next [3];
  logic [7:0]  hem      [2];
  logic [7:0]  hem_next [2];
  logic        overflow_seen,  overflow_seen_next;
  logic        text_ended,     text_ended_next;

  // Output register
  logic    res_valid;
  result_t res;
  result_t res_next;

  logic        accept;
  logic [7:0]  b;
  logic        is_end, finish, abort, keep;
  logic        num_field;
  logic [1:0]  slot;
  logic [29:0] acc_sel;
  logic [3:0]  frac_sel;
  logic        ap_eff, ds_eff;
  logic        is_digit;
  logic [33:0] prod;
  logic        digit_ovf;
  logic        has_speed;
  logic [2:0]  status;
  logic        is_rmc;

  assign serial.ready = !res_valid || report.ready;
  assign accept       = serial.valid && serial.ready;
  assign b            = serial.rx_byte;

  assign is_end = (b == CH_CR) || (b == CH_LF);
  assign finish = is_end || (stored_count >= LIMIT);
  assign abort  = !finish && (b == CH_DOLLAR) && (stored_count != 7'd0);
  assign keep   = !finish && !abort && ((b == CH_DOLLAR) || (stored_count != 7'd0));

  // Shared decimal accumulate for whichever numeric field is open
  always_comb begin
    case (token_number)
      TOK_LAT:   slot = 2'd0;
      TOK_LON:   slot = 2'd1;
      default:   slot = 2'd2;
    endcase
  end
  assign num_field = (token_number == TOK_LAT) || (token_number == TOK_LON) ||
                     (token_number == TOK_SPEED);
  assign acc_sel  = acc[slot];
  assign frac_sel = frac[slot];
  // A new field starts with the point flag and stop flag cleared
  assign ap_eff   = token_nonempty && after_point;
  assign ds_eff   = token_nonempty && digit_stop;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign prod     = ({4'd0, acc_sel} << 3) + ({4'd0, acc_sel} << 1) + {30'd0, b[3:0]};
  assign digit_ovf = (prod > DIGIT_MAX) || (ap_eff && (frac_sel >= FRAC_MAX));

  always_comb begin
    stored_count_next   = stored_count;
    prefix_match_next   = prefix_match;
    id_match_pos_next   = id_match_pos;
    id_is_rmc_next      = id_is_rmc;
    token_number_next   = token_number;
    token_nonempty_next = token_nonempty;
    after_point_next    = after_point;
    digit_stop_next     = digit_stop;
    acc_next            = acc;
    frac_next           = frac;
    hem_next            = hem;
    overflow_seen_next  = overflow_seen;
    text_ended_next     = text_ended;

    if (accept && (finish || abort)) begin
      stored_count_next   = 7'd0;
      prefix_match_next   = 2'd0;
      id_match_pos_next   = 3'd0;
      id_is_rmc_next      = 1'b0;
      token_number_next   = 4'd0;
      token_nonempty_next = 1'b0;
      after_point_next    = 1'b0;
      digit_stop_next     = 1'b0;
      acc_next            = '{default: '0};
      frac_next           = '{default: '0};
      hem_next            = '{default: '0};
      overflow_seen_next  = 1'b0;
      text_ended_next     = 1'b0;
    end else if (accept && keep) begin
      stored_count_next = stored_count + 7'd1;
      if ((stored_count < 7'(PREFIX_LEN)) && (7'(prefix_match) == stored_count) &&
          (b == prefix_char(prefix_match))) begin
        prefix_match_next = prefix_match + 2'd1;
      end
      if (!text_ended) begin
        if (b == CH_NUL) begin
          text_ended_next = 1'b1;
        end else if (b == CH_COMMA) begin
          if (token_nonempty) begin
            if (token_number < TOK_MAX) token_number_next = token_number + 4'd1;
            token_nonempty_next = 1'b0;
          end
        end else begin
          if (!token_nonempty) begin
            token_nonempty_next = 1'b1;
            after_point_next    = 1'b0;
            digit_stop_next     = 1'b0;
            if (token_number == TOK_LAT_HEM) hem_next[0] = b;
            else if (token_number == TOK_LON_HEM) hem_next[1] = b;
          end
          if (token_number == TOK_ID) begin
            if ((id_match_pos < ID_LEN) && (b == id_char(id_match_pos))) begin
              id_match_pos_next = id_match_pos + 3'd1;
            end else begin
              id_match_pos_next = ID_MISMATCH;
            end
            id_is_rmc_next = (id_match_pos_next == ID_LEN);
          end else if (num_field && !ds_eff) begin
            if (is_digit) begin
              if (digit_ovf) begin
                overflow_seen_next = 1'b1;
                digit_stop_next    = 1'b1;
              end else begin
                acc_next[slot] = prod[29:0];
                if (ap_eff) frac_next[slot] = frac_sel + 4'd1;
              end
            end else if ((b == CH_POINT) && !ap_eff) begin
              after_point_next = 1'b1;
            end else begin
              digit_stop_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // Result of the sentence that ends with this character
  assign has_speed = (token_number > TOK_SPEED) ||
                     ((token_number == TOK_SPEED) && token_nonempty);
  always_comb begin
    if (abort) begin
      status = ST_ABORT;
    end else if ((stored_count >= 7'(PREFIX_LEN)) && (prefix_match == PREFIX_LEN)) begin
      if (id_is_rmc) status = has_speed ? ST_RMC_OK : ST_RMC_SHORT;
      else           status = ST_GP_OTHER;
    end else begin
      status = ST_BAD_PREFIX;
    end
  end
  assign is_rmc = (status == ST_RMC_OK) || (status == ST_RMC_SHORT);

  always_comb begin
    res_next           = '0;
    res_next.status    = status;
    res_next.truncated = finish && !is_end;
    res_next.length    = stored_count;
    if (is_rmc) begin
      res_next.lat_digits       = acc[0];
      res_next.lat_frac_count   = frac[0];
      res_next.lat_hemisphere   = hem[0];
      res_next.lon_digits       = acc[1];
      res_next.lon_frac_count   = frac[1];
      res_next.lon_hemisphere   = hem[1];
      res_next.speed_digits     = acc[2];
      res_next.speed_frac_count = frac[2];
      res_next.number_overflow  = overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count   <= 7'd0;
      prefix_match   <= 2'd0;
      id_match_pos   <= 3'd0;
      id_is_rmc      <= 1'b0;
      token_number   <= 4'd0;
      token_nonempty <= 1'b0;
      after_point    <= 1'b0;
      digit_stop     <= 1'b0;
      acc            <= '{default: '0};
      frac           <= '{default: '0};
      hem            <= '{default: '0};
      overflow_seen  <= 1'b0;
      text_ended     <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      stored_count   <= stored_count_next;
      prefix_match   <= prefix_match_next;
      id_match_pos   <= id_match_pos_next;
      id_is_rmc      <= id_is_rmc_next;
      token_number   <= token_number_next;
      token_nonempty <= token_nonempty_next;
      after_point    <= after_point_next;
      digit_stop     <= digit_stop_next;
      acc            <= acc_next;
      frac           <= frac_next;
      hem            <= hem_next;
      overflow_seen  <= overflow_seen_next;
      text_ended     <= text_ended_next;
      if (accept && (finish || abort)) begin
        res_valid <= 1'b1;
      end else if (report.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (finish || abort)) res <= res_next;
  end

  assign report.valid  = res_valid;
  assign report.result = res;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= LIMIT)
    else $error("kept character count above limit");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (finish || abort)) |=> report.valid)
    else $error("sentence end without a result");

  a_prefix_needs_count: assert property (@(posedge clk) disable iff (rst)
    (prefix_match == PREFIX_LEN) |-> (stored_count >= 7'(PREFIX_LEN)))
    else $error("prefix matched with too few characters");

  a_abort_not_truncated: assert property (@(posedge clk) disable iff (rst)
    (report.valid && (report.result.status == ST_ABORT)) |->
      (!report.result.truncated && (report.result.lat_digits == 30'd0) &&
       !report.result.number_overflow))
    else $error("aborted sentence carries field data");

  a_rmc_id_tracks: assert property (@(posedge clk) disable iff (rst)
    id_is_rmc |-> (id_match_pos == ID_LEN))
    else $error("RMC flag without full id match");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the NMEA RMC sentence parser
// Feeds character streams (typed sentences, then random RMC, other GP, bad
// and noisy lines) with random gaps on both channels, and checks every
// report against a typed result or a cycle-free model of the sentence parse.
// ----------------------------------------------------------------------------
module tb_top;
  import nrp_pkg::*;

  localparam int SENT_MAX    = 80;
  localparam int ITEM_TOTAL  = 1050;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst;

  nrp_byte_if   ser_ch ();
  nrp_result_if rep_ch ();

  nmea_rmc_sentence_parser_top #(.MAX_LEN(SENT_MAX)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .serial (ser_ch),
    .report (rep_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sentence parse state of the model
  string       rmc_tag = "$GPRMC";
  int          sen_len;
  int          gp_hits;
  logic [2:0]  id_pos;
  bit          id_rmc;
  logic [3:0]  fld_no;
  bit          fld_open;
  bit          past_point;
  bit          num_done;
  int unsigned num_val [3];
  logic [3:0]  num_frac [3];
  logic [7:0]  hemi [2];
  bit          num_ovf;
  bit          text_done;

  result_t     report_q [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          item_cnt = 0;

  // Shared between the sender and the receiver
  bit          calm = 1'b0;
  int          hold_req = 0;

  // Directed rows: text ('~' stands for a NUL), ending character, and
  // optionally a typed status / truncated / length
  string       row_text [$];
  logic [7:0]  row_end [$];
  bit          row_typed [$];
  logic [2:0]  row_st [$];
  bit          row_tr [$];
  int          row_len [$];

  logic [7:0]  line_q [$];

  function automatic void sentence_clear();
    sen_len    = 0;
    gp_hits    = 0;
    id_pos     = '0;
    id_rmc     = 1'b0;
    fld_no     = '0;
    fld_open   = 1'b0;
    past_point = 1'b0;
    num_done   = 1'b0;
    num_ovf    = 1'b0;
    text_done  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num_val[i]  = 0;
      num_frac[i] = '0;
    end
    hemi[0] = '0;
    hemi[1] = '0;
  endfunction

  function automatic void parse_kept(int pos, logic [7:0] b);
    int          slot;
    int unsigned d;
    if (pos < 3 && gp_hits == pos && b == rmc_tag[pos]) gp_hits++;
    if (text_done) return;
    if (b == CH_NUL) begin
      text_done = 1'b1;
      return;
    end
    if (b == CH_COMMA) begin
      if (fld_open) begin
        if (fld_no < TOK_MAX) fld_no++;
        fld_open = 1'b0;
      end
      return;
    end
    if (!fld_open) begin
      fld_open   = 1'b1;
      past_point = 1'b0;
      num_done   = 1'b0;
      if (fld_no == TOK_LAT_HEM) hemi[0] = b;
      else if (fld_no == TOK_LON_HEM) hemi[1] = b;
    end
    slot = -1;
    if (fld_no == TOK_ID) begin
      if (id_pos < ID_LEN && b == rmc_tag[id_pos]) id_pos++;
      else id_pos = ID_MISMATCH;
      id_rmc = (id_pos == ID_LEN);
    end else if (fld_no == TOK_LAT) begin
      slot = 0;
    end else if (fld_no == TOK_LON) begin
      slot = 1;
    end else if (fld_no == TOK_SPEED) begin
      slot = 2;
    end
    if (slot < 0 || num_done) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = b - CH_ZERO;
      if (34'(num_val[slot]) > (DIGIT_MAX - 34'(d)) / 34'd10 ||
          (past_point && num_frac[slot] >= FRAC_MAX)) begin
        num_ovf  = 1'b1;
        num_done = 1'b1;
      end else begin
        num_val[slot] = num_val[slot] * 10 + d;
        if (past_point) num_frac[slot]++;
      end
    end else if (b == CH_POINT && !past_point) begin
      past_point = 1'b1;
    end else begin
      num_done = 1'b1;
    end
  endfunction

  function automatic result_t make_report(logic [2:0] st, bit tr);
    result_t r;
    r           = '0;
    r.status    = st;
    r.truncated = tr;
    r.length    = 7'(sen_len);
    if (st == ST_RMC_OK || st == ST_RMC_SHORT) begin
      r.lat_digits       = num_val[0][29:0];
      r.lat_frac_count   = num_frac[0];
      r.lat_hemisphere   = hemi[0];
      r.lon_digits       = num_val[1][29:0];
      r.lon_frac_count   = num_frac[1];
      r.lon_hemisphere   = hemi[1];
      r.speed_digits     = num_val[2][29:0];
      r.speed_frac_count = num_frac[2];
      r.number_overflow  = num_ovf;
    end
    return r;
  endfunction

  // One character through the model; got is set when it ends a sentence
  function automatic void predict_char(logic [7:0] b, output bit got,
                                       output result_t r);
    bit         line_end;
    logic [2:0] st;
    line_end = (b == CH_CR || b == CH_LF);
    got      = 1'b0;
    r        = '0;
    if (line_end || sen_len >= SENT_MAX) begin
      if (sen_len >= 3 && gp_hits == 3) begin
        if (id_rmc)
          st = (fld_no > TOK_SPEED || (fld_no == TOK_SPEED && fld_open)) ?
               ST_RMC_OK : ST_RMC_SHORT;
        else
          st = ST_GP_OTHER;
      end else begin
        st = ST_BAD_PREFIX;
      end
      r   = make_report(st, !line_end);
      got = 1'b1;
      sentence_clear();
    end else if (b == CH_DOLLAR && sen_len > 0) begin
      r   = make_report(ST_ABORT, 1'b0);
      got = 1'b1;
      sentence_clear();
    end else if (b == CH_DOLLAR || sen_len > 0) begin
      parse_kept(sen_len, b);
      sen_len++;
    end
  endfunction

  function automatic string report_str(result_t r);
    return $sformatf("st=%0d tr=%0d len=%0d lat=%0d/%0d/%02h lon=%0d/%0d/%02h spd=%0d/%0d ov=%0d",
                     r.status, r.truncated, r.length, r.lat_digits, r.lat_frac_count,
                     r.lat_hemisphere, r.lon_digits, r.lon_frac_count, r.lon_hemisphere,
                     r.speed_digits, r.speed_frac_count, r.number_overflow);
  endfunction

  // Predict at offer time, then hold the character until it is taken
  task automatic put_byte(logic [7:0] b, bit typed, result_t typed_rep);
    int      gap;
    bit      got;
    result_t r;
    item_cnt++;
    predict_char(b, got, r);
    if (got) report_q.push_back(typed ? typed_rep : r);
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      ser_ch.valid = 1'b0;
    end
    @(negedge clk);
    ser_ch.valid   = 1'b1;
    ser_ch.rx_byte = b;
    do @(posedge clk); while (!ser_ch.ready);
  endtask

  function automatic void add_row(string txt, logic [7:0] e, bit typed,
                                  logic [2:0] st, bit tr, int len);
    row_text.push_back(txt);
    row_end.push_back(e);
    row_typed.push_back(typed);
    row_st.push_back(st);
    row_tr.push_back(tr);
    row_len.push_back(len);
  endfunction

  function automatic string pad_to(string s, int n, string c);
    string t;
    t = s;
    while (t.len() < n) t = {t, c};
    return t;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void push_rand_letters(int n);
    for (int i = 0; i < n; i++) line_q.push_back(8'($urandom_range(65, 90)));
  endfunction

  function automatic void add_number();
    int k;
    int n_int;
    int n_frac;
    k      = $urandom_range(0, 19);
    n_int  = (k == 0) ? 0 : (k == 1) ? $urandom_range(9, 12) : $urandom_range(1, 5);
    n_frac = (k == 2) ? $urandom_range(8, 11) : $urandom_range(0, 4);
    for (int i = 0; i < n_int; i++)
      line_q.push_back((k == 3) ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 24) == 0) line_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) begin
      line_q.push_back(CH_POINT);
      for (int i = 0; i < n_frac; i++)
        line_q.push_back((k == 3) ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_hemi(logic [7:0] a, logic [7:0] b);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      line_q.push_back(a);
      push_rand_letters($urandom_range(1, 4));
    end else if (k == 1) begin
      line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      line_q.push_back($urandom_range(0, 1) ? a : b);
    end
  endfunction

  // Mostly RMC lines with random content; other GP ids, bad prefixes, noise
  function automatic void build_line();
    int kind;
    int nf;
    int k;
    line_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 62) begin
      push_text(rmc_tag);
    end else if (kind < 77) begin
      push_text("$GP");
      case ($urandom_range(0, 3))
        0: push_rand_letters(3);
        1: begin
          push_text("RMC");
          push_rand_letters(1);
        end
        2: push_text("RM");
        default: push_text("RMB");
      endcase
    end else if (kind < 87) begin
      push_text("$");
      repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom_range(33, 126)));
    end else begin
      push_text("$G");
      push_rand_letters($urandom_range(0, 4));
    end
    nf = ($urandom_range(0, 3) != 0) ? 11 : $urandom_range(0, 11);
    for (int j = 1; j <= nf; j++) begin
      line_q.push_back(CH_COMMA);
      if ($urandom_range(0, 11) == 0) continue;
      case (j)
        2:       push_text($urandom_range(0, 1) ? "A" : "V");
        4:       add_hemi("N", "S");
        6, 11:   add_hemi("E", "W");
        default: add_number();
      endcase
    end
    if ($urandom_range(0, 19) == 0)
      while (line_q.size() < 85) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      push_text("*");
      push_rand_letters(2);
    end
    k = $urandom_range(0, 19);
    if (k == 0) line_q.push_back(CH_DOLLAR);
    else if (k == 1) ;
    else if (k < 9) line_q.push_back(CH_CR);
    else if (k < 13) line_q.push_back(CH_LF);
    else begin
      line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
    end
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Report side: random stall per transfer, long hold on request
  initial begin
    int      stall;
    result_t want;
    rep_ch.ready = 1'b0;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
      end
      repeat (stall) begin
        @(negedge clk);
        rep_ch.ready = 1'b0;
      end
      @(negedge clk);
      rep_ch.ready = 1'b1;
      do @(posedge clk); while (!rep_ch.valid);
      if (report_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected report: %s", report_str(rep_ch.result));
      end else begin
        want = report_q.pop_front();
        if (rep_ch.result !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("report mismatch at cycle %0d", cycle_cnt);
            $display("  exp %s", report_str(want));
            $display("  got %s", report_str(rep_ch.result));
          end
        end
      end
    end
  end

  initial begin
    result_t    typed_rep;
    logic [7:0] b;
    string      s;
    int         line_no;
    int         press_left;
    rst            = 1'b1;
    ser_ch.valid   = 1'b0;
    ser_ch.rx_byte = '0;
    sentence_clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row("", CH_CR, 1, ST_BAD_PREFIX, 0, 0);
    add_row("", CH_LF, 1, ST_BAD_PREFIX, 0, 0);
    add_row("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A",
            CH_CR, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPGGA,123519,4807.038,N,01131.000,E,1,08", CH_LF, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPRMC,1,A,4916.45,N,12311.12,W", CH_CR, 0, ST_GP_OTHER, 0, 0);
    // empty fields are skipped, so every field still lands in its slot
    add_row("$GPRMC,,1,,A,,4.5,,S,,12.25,,E,,0.75,,", CH_LF, 0, ST_GP_OTHER, 0, 0);
    // largest value, too many digits, too many fraction digits
    add_row("$GPRMC,1,A,999999999,N,9999999999,W,1.9999999999", CH_CR, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPRMC,1,A,12a34,North,.5.5,West,.", CH_LF, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPRMC,1,A,48~07,N,1,E,2", CH_CR, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPR", CH_DOLLAR, 1, ST_ABORT, 0, 4);
    add_row("$", CH_DOLLAR, 1, ST_ABORT, 0, 1);
    add_row("xyz", CH_CR, 1, ST_BAD_PREFIX, 0, 0);
    add_row("$GXRMC", CH_CR, 1, ST_BAD_PREFIX, 0, 6);
    add_row("$G", CH_LF, 1, ST_BAD_PREFIX, 0, 2);
    add_row("$GPRMCX,1,A,2,N,3,E,4", CH_CR, 0, ST_GP_OTHER, 0, 0);
    add_row("$GPRM", CH_CR, 1, ST_GP_OTHER, 0, 5);
    add_row(pad_to("$GPGGA,", SENT_MAX, "7"), "Z", 1, ST_GP_OTHER, 1, SENT_MAX);
    add_row(pad_to("$GPGGA,", SENT_MAX, "7"), CH_CR, 1, ST_GP_OTHER, 0, SENT_MAX);
    add_row(pad_to("$ABC,", SENT_MAX, ","), CH_DOLLAR, 1, ST_BAD_PREFIX, 1, SENT_MAX);
    add_row(pad_to("$GPRMC,1,A,4807.038,N,01131.000,E,022.4,", SENT_MAX, "5"), "Q",
            0, ST_GP_OTHER, 0, 0);

    for (int i = 0; i < row_text.size(); i++) begin
      calm                = ($urandom_range(0, 3) == 0);
      typed_rep           = '0;
      typed_rep.status    = row_st[i];
      typed_rep.truncated = row_tr[i];
      typed_rep.length    = 7'(row_len[i]);
      s = row_text[i];
      for (int j = 0; j < s.len(); j++) begin
        b = s[j];
        if (b == "~") b = CH_NUL;
        put_byte(b, row_typed[i], typed_rep);
      end
      put_byte(row_end[i], row_typed[i], typed_rep);
    end

    line_no    = 0;
    press_left = 0;
    typed_rep  = '0;
    while (item_cnt < ITEM_TOTAL) begin
      // block the report side for a long while and keep sending
      if (line_no == 1 || line_no == 4) begin
        hold_req   = 300;
        press_left = 6;
      end
      if (press_left > 0) begin
        calm = 1'b1;
        press_left--;
      end else begin
        calm = ($urandom_range(0, 5) == 0);
      end
      build_line();
      foreach (line_q[j]) put_byte(line_q[j], 1'b0, typed_rep);
      line_no++;
    end
    // close any sentence left open
    put_byte(CH_CR, 1'b0, typed_rep);

    @(negedge clk);
    ser_ch.valid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
src/nrp_pkg.sv
src/nrp_ifs.sv
src/nmea_rmc_sentence_parser_top.sv
test/tb_top.sv
